>>> design/wmcc_pkg.sv
// Shared types and constants for the washing machine cycle controller.
// Used by wmcc_step and by the top level; depends on nothing else.
package wmcc_pkg;

  // Event codes carried on the input channel
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_POWER_BTN  = 3'd1;
  localparam logic [2:0] CMD_ADV_BTN    = 3'd2;
  localparam logic [2:0] CMD_REMOTE_ON  = 3'd3;
  localparam logic [2:0] CMD_REMOTE_OFF = 3'd4;
  localparam logic [2:0] CMD_REMOTE_ADV = 3'd5;
  localparam logic [2:0] CMD_QUERY      = 3'd6;
  localparam logic [2:0] CMD_SPARE      = 3'd7;

  // Wash phases
  localparam logic [3:0] PH_OFF        = 4'd0;
  localparam logic [3:0] PH_FILL       = 4'd1;
  localparam logic [3:0] PH_AGITATE    = 4'd2;
  localparam logic [3:0] PH_DRAIN      = 4'd3;
  localparam logic [3:0] PH_SPIN       = 4'd4;
  localparam logic [3:0] PH_RINSE_FILL = 4'd5;
  localparam logic [3:0] PH_AGITATE2   = 4'd6;
  localparam logic [3:0] PH_DRAIN2     = 4'd7;
  localparam logic [3:0] PH_SPIN2      = 4'd8;
  localparam logic [3:0] PH_SHUTDOWN   = 4'd9;

  localparam logic [7:0] TICKS_RESET = 8'd5;

  // Lamps and drives
  typedef struct packed {
    logic motor;
    logic valve;
    logic level;
    logic power;
  } drive_t;

  // Sequencer state carried from item to item
  typedef struct packed {
    logic [3:0] phase;
    logic [7:0] countdown;
    logic       counting;
    drive_t     drive;
  } seq_state_t;

  // One result item
  typedef struct packed {
    logic [3:0] report_code;
    logic       report_valid;
    logic       timing;
    logic [7:0] ticks_left;
    logic [3:0] current_phase;
    drive_t     drive;
  } result_t;

  // Phase that follows p; shut-down and anything past it wrap to off
  function automatic logic [3:0] next_phase(input logic [3:0] p);
    next_phase = (p >= PH_SHUTDOWN) ? PH_OFF : p + 4'd1;
  endfunction

endpackage

>>> design/wmcc_step.sv
// Next-state and result logic for one event of the wash sequencer.
// Purely combinational; uses types and constants from wmcc_pkg.
module wmcc_step (
  input  wmcc_pkg::seq_state_t st,
  input  logic [2:0]           command,
  input  logic                 level_high_reached,
  input  logic                 level_low_reached,
  input  logic [7:0]           timed_phase_ticks,
  output wmcc_pkg::seq_state_t st_nxt,
  output wmcc_pkg::result_t    res
);

  always_comb begin
    wmcc_pkg::seq_state_t s;
    logic                 eval;
    logic                 rep_v;
    logic [3:0]           rep_c;

    s     = st;
    eval  = 1'b0;
    rep_v = 1'b0;
    rep_c = 4'd0;

    // Apply the event
    unique case (command) inside
      wmcc_pkg::CMD_TICK, wmcc_pkg::CMD_SPARE: begin
        if (st.counting) begin
          if (st.countdown == 8'd0) begin
            s.counting = 1'b0;
            rep_v      = 1'b1;
            rep_c      = st.phase;
            s.phase    = wmcc_pkg::next_phase(st.phase);
          end else begin
            s.countdown = st.countdown - 8'd1;
          end
        end else begin
          eval = (st.phase != wmcc_pkg::PH_OFF);
        end
      end
      wmcc_pkg::CMD_QUERY: begin
        eval = !st.counting;
      end
      default: begin
        unique case (command)
          wmcc_pkg::CMD_POWER_BTN:
            s.phase = (st.phase == wmcc_pkg::PH_OFF) ? wmcc_pkg::PH_FILL : wmcc_pkg::PH_OFF;
          wmcc_pkg::CMD_ADV_BTN:
            if (st.phase != wmcc_pkg::PH_OFF) s.phase = wmcc_pkg::next_phase(st.phase);
          wmcc_pkg::CMD_REMOTE_ON:  s.phase = wmcc_pkg::PH_FILL;
          wmcc_pkg::CMD_REMOTE_OFF: s.phase = wmcc_pkg::PH_SHUTDOWN;
          default:                  s.phase = wmcc_pkg::next_phase(st.phase);
        endcase
        // Drop any countdown in progress
        s.counting  = 1'b0;
        s.countdown = 8'd0;
        eval        = 1'b1;
      end
    endcase

    // Evaluate the current phase once
    if (eval) begin
      unique case (s.phase) inside
        wmcc_pkg::PH_FILL: begin
          s.drive.power = 1'b1;
          s.drive.motor = 1'b1;
          s.drive.valve = 1'b1;
          rep_v   = 1'b1;
          rep_c   = wmcc_pkg::PH_FILL;
          s.phase = wmcc_pkg::PH_AGITATE;
        end
        wmcc_pkg::PH_AGITATE, wmcc_pkg::PH_AGITATE2: begin
          if (level_high_reached) begin
            s.drive.level = 1'b1;
            s.drive.valve = 1'b0;
            s.drive.motor = 1'b1;
            s.countdown   = timed_phase_ticks;
            s.counting    = 1'b1;
          end
        end
        wmcc_pkg::PH_DRAIN, wmcc_pkg::PH_DRAIN2: begin
          s.drive.level = 1'b0;
          s.drive.motor = 1'b0;
          s.drive.valve = 1'b1;
          rep_v   = 1'b1;
          rep_c   = s.phase;
          s.phase = s.phase + 4'd1;
        end
        wmcc_pkg::PH_SPIN, wmcc_pkg::PH_SPIN2: begin
          if (level_low_reached) begin
            s.drive.level = 1'b1;
            s.drive.motor = 1'b1;
            s.countdown   = timed_phase_ticks;
            s.counting    = 1'b1;
          end
        end
        wmcc_pkg::PH_RINSE_FILL: begin
          s.drive.motor = 1'b1;
          s.drive.valve = 1'b1;
          s.drive.level = 1'b0;
          rep_v   = 1'b1;
          rep_c   = wmcc_pkg::PH_RINSE_FILL;
          s.phase = wmcc_pkg::PH_AGITATE2;
        end
        default: begin
          // Off, shut-down and unused codes: everything off
          s.drive     = '0;
          s.counting  = 1'b0;
          s.countdown = 8'd0;
          rep_v       = 1'b1;
          rep_c       = wmcc_pkg::PH_OFF;
          s.phase     = wmcc_pkg::PH_OFF;
        end
      endcase
    end

    st_nxt            = s;
    res.drive         = s.drive;
    res.current_phase = s.phase;
    res.ticks_left    = s.counting ? s.countdown : 8'd0;
    res.timing        = s.counting;
    res.report_valid  = rep_v;
    res.report_code   = rep_v ? rep_c : 4'd0;
  end

endmodule

>>> design/washing_machine_cycle_controller_core.sv
// Top level of the washing machine cycle controller: input register, sequencer
// state, result register and configuration register. Uses wmcc_pkg and wmcc_step.
//
// Usage:
//   Input channel (in_*): one event per item. in_tuser carries the command,
//   in_tdata the two level sensor flags.
//   Result channel (out_*): exactly one result item per input item, in order.
//   Configuration channel (cfg_*): writes timed_phase_ticks, the countdown start value
//   for agitate and spin phases; always ready; the user writes it only idle (not enforced).
// Path: an accepted input item is held in the input register, then the sequencer
//   step writes its result into the result register.
// Throughput: one item per cycle while results are taken; the sequencer step is a single
//   pass of logic from the input register and the state registers.
// Reset: phase off, countdown cleared, drives off, timed_phase_ticks = 5,
//   both channels empty.
// Stall: while the result is not taken, the result register holds its item and
//   the input register can hold one more; in_tready drops only while both are
//   full and out_tready is low.
module washing_machine_cycle_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] level_high_reached, [1] level_low_reached, [7:2] zero
  input  logic [2:0]  in_tuser,   // [2:0] command
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] power_lamp, [1] level_lamp, [2] valve_on,
                                  // [3] motor_on, [7:4] current_phase, [15:8] ticks_left,
                                  // [16] timing, [17] report_valid, [21:18] report_code,
                                  // [23:22] zero
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // timed_phase_ticks
);

  logic                 in_valid_r;
  logic [2:0]           cmd_r;
  logic                 hi_r;
  logic                 lo_r;
  logic                 out_valid_r;
  wmcc_pkg::result_t    res_r;
  wmcc_pkg::result_t    res_nxt;
  wmcc_pkg::seq_state_t st_r;
  wmcc_pkg::seq_state_t st_nxt;
  logic [7:0]           ticks_r;
  logic                 advance;

  // Step the sequencer when an item is held and the result slot is free
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  wmcc_step u_step (
    .st                 (st_r),
    .command            (cmd_r),
    .level_high_reached (hi_r),
    .level_low_reached  (lo_r),
    .timed_phase_ticks  (ticks_r),
    .st_nxt             (st_nxt),
    .res                (res_nxt)
  );

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      ticks_r     <= wmcc_pkg::TICKS_RESET;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) ticks_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r <= in_tuser;
      hi_r  <= in_tdata[0];
      lo_r  <= in_tdata[1];
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

  // Checks
  a_report_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.report_valid |-> res_r.report_code == 4'd0)
    else $error("report code set without report");

  a_ticks_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.timing |-> res_r.ticks_left == 8'd0)
    else $error("ticks shown outside a timed phase");

  a_off_all_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.current_phase == wmcc_pkg::PH_OFF
      |-> res_r.drive == '0 && !res_r.timing)
    else $error("drives active while off");

  a_timing_phase: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.counting |-> (st_r.phase == wmcc_pkg::PH_AGITATE || st_r.phase == wmcc_pkg::PH_SPIN ||
                       st_r.phase == wmcc_pkg::PH_AGITATE2 || st_r.phase == wmcc_pkg::PH_SPIN2))
    else $error("countdown outside agitate or spin");

endmodule

>>> tb/washing_machine_cycle_controller_core_tb.sv
// Self-checking testbench for washing_machine_cycle_controller_core: a directed
// table, then random event sequences under several countdown settings.
// Depends on wmcc_pkg and the core RTL only.
module washing_machine_cycle_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEMS_PER_SETTING = 100;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // One row of the directed table; want is used only when known is set
  typedef struct packed {
    logic [2:0]        cmd;
    logic              hi;
    logic              lo;
    logic              known;
    wmcc_pkg::result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [2:0]  in_tuser = wmcc_pkg::CMD_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  wmcc_pkg::result_t expected_results[$];
  stim_row_t         dir_rows [0:25];
  int                mismatches = 0;
  int                idle_cycles = 0;

  // Sequencer model state
  logic [3:0]       wash_phase = wmcc_pkg::PH_OFF;
  logic [7:0]       count_left = '0;
  logic             counting_down = 1'b0;
  wmcc_pkg::drive_t lamps = '0;
  logic [7:0]       phase_ticks = wmcc_pkg::TICKS_RESET;
  logic             note_valid;
  logic [3:0]       note_code;

  // Receiver stall pattern
  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_span = 0;
  logic [7:0] rx_pat = 8'b1011_0010;

  washing_machine_cycle_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [0] level_high_reached, [1] level_low_reached
    .in_tuser   (in_tuser),   // [2:0] command
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [3:0] drives, [7:4] phase, [15:8] ticks_left,
                              // [16] timing, [17] report_valid, [21:18] report_code
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [3:0] phase_after(input logic [3:0] p);
    return (p >= wmcc_pkg::PH_SHUTDOWN) ? wmcc_pkg::PH_OFF : p + 4'd1;
  endfunction

  // Run the current phase once: set drives, report, move on or start the countdown
  task automatic settle_phase(input logic hi, input logic lo);
    case (wash_phase)
      wmcc_pkg::PH_FILL: begin
        lamps.power = 1'b1;
        lamps.motor = 1'b1;
        lamps.valve = 1'b1;
        note_valid = 1'b1;
        note_code = wmcc_pkg::PH_FILL;
        wash_phase = wmcc_pkg::PH_AGITATE;
      end
      wmcc_pkg::PH_AGITATE, wmcc_pkg::PH_AGITATE2: begin
        if (hi) begin
          lamps.level = 1'b1;
          lamps.valve = 1'b0;
          lamps.motor = 1'b1;
          count_left = phase_ticks;
          counting_down = 1'b1;
        end
      end
      wmcc_pkg::PH_DRAIN, wmcc_pkg::PH_DRAIN2: begin
        lamps.level = 1'b0;
        lamps.motor = 1'b0;
        lamps.valve = 1'b1;
        note_valid = 1'b1;
        note_code = wash_phase;
        wash_phase = wash_phase + 4'd1;
      end
      wmcc_pkg::PH_SPIN, wmcc_pkg::PH_SPIN2: begin
        if (lo) begin
          lamps.level = 1'b1;
          lamps.motor = 1'b1;
          count_left = phase_ticks;
          counting_down = 1'b1;
        end
      end
      wmcc_pkg::PH_RINSE_FILL: begin
        lamps.motor = 1'b1;
        lamps.valve = 1'b1;
        lamps.level = 1'b0;
        note_valid = 1'b1;
        note_code = wmcc_pkg::PH_RINSE_FILL;
        wash_phase = wmcc_pkg::PH_AGITATE2;
      end
      default: begin
        lamps = '0;
        counting_down = 1'b0;
        count_left = '0;
        note_valid = 1'b1;
        note_code = wmcc_pkg::PH_OFF;
        wash_phase = wmcc_pkg::PH_OFF;
      end
    endcase
  endtask

  // Apply one event to the sequencer and form the result it produces
  task automatic wash_step(input logic [2:0] cmd, input logic hi, input logic lo,
                           output wmcc_pkg::result_t r);
    note_valid = 1'b0;
    note_code = wmcc_pkg::PH_OFF;
    case (cmd)
      wmcc_pkg::CMD_TICK, wmcc_pkg::CMD_SPARE: begin
        if (counting_down) begin
          if (count_left == 8'd0) begin
            counting_down = 1'b0;
            note_valid = 1'b1;
            note_code = wash_phase;
            wash_phase = phase_after(wash_phase);
          end else begin
            count_left = count_left - 8'd1;
          end
        end else if (wash_phase != wmcc_pkg::PH_OFF) begin
          settle_phase(hi, lo);
        end
      end
      wmcc_pkg::CMD_QUERY: begin
        if (!counting_down) settle_phase(hi, lo);
      end
      default: begin
        case (cmd)
          wmcc_pkg::CMD_POWER_BTN:
            wash_phase = (wash_phase == wmcc_pkg::PH_OFF) ? wmcc_pkg::PH_FILL
                                                          : wmcc_pkg::PH_OFF;
          wmcc_pkg::CMD_ADV_BTN:
            if (wash_phase != wmcc_pkg::PH_OFF) wash_phase = phase_after(wash_phase);
          wmcc_pkg::CMD_REMOTE_ON:  wash_phase = wmcc_pkg::PH_FILL;
          wmcc_pkg::CMD_REMOTE_OFF: wash_phase = wmcc_pkg::PH_SHUTDOWN;
          default:                  wash_phase = phase_after(wash_phase);
        endcase
        counting_down = 1'b0;
        count_left = '0;
        settle_phase(hi, lo);
      end
    endcase
    r.drive = lamps;
    r.current_phase = wash_phase;
    r.ticks_left = counting_down ? count_left : 8'd0;
    r.timing = counting_down;
    r.report_valid = note_valid;
    r.report_code = note_valid ? note_code : wmcc_pkg::PH_OFF;
  endtask

  function automatic wmcc_pkg::result_t res(input logic pwr, input logic lvl, input logic vlv,
                                            input logic mot, input logic [3:0] ph,
                                            input logic [7:0] ticks, input logic tim,
                                            input logic rv, input logic [3:0] rc);
    wmcc_pkg::result_t r;
    r.drive.power = pwr;
    r.drive.level = lvl;
    r.drive.valve = vlv;
    r.drive.motor = mot;
    r.current_phase = ph;
    r.ticks_left = ticks;
    r.timing = tim;
    r.report_valid = rv;
    r.report_code = rc;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [2:0] cmd, input logic hi, input logic lo,
                                    input logic known, input wmcc_pkg::result_t want);
    stim_row_t s;
    s.cmd = cmd;
    s.hi = hi;
    s.lo = lo;
    s.known = known;
    s.want = want;
    return s;
  endfunction

  // Offer one item and hold it until accepted, then queue its expected result
  task automatic send_item(input logic [2:0] cmd, input logic hi, input logic lo,
                           input logic known, input wmcc_pkg::result_t want);
    wmcc_pkg::result_t predicted;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {6'b0, lo, hi};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    wash_step(cmd, hi, lo, predicted);
    expected_results.push_back(known ? want : predicted);
  endtask

  task automatic hold_off(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write the countdown start value once the block has gone idle
  task automatic write_phase_ticks(input logic [7:0] v);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    phase_ticks = v;
    cfg_valid <= 1'b0;
  endtask

  // Mostly ticks with random sensor levels, sprinkled with buttons and remote commands
  task automatic run_random(input int n);
    int left;
    int burst;
    int r;
    logic [2:0] cmd;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        r = $urandom_range(0, 99);
        if (r < 70)      cmd = wmcc_pkg::CMD_TICK;
        else if (r < 74) cmd = wmcc_pkg::CMD_SPARE;
        else if (r < 80) cmd = wmcc_pkg::CMD_QUERY;
        else if (r < 84) cmd = wmcc_pkg::CMD_POWER_BTN;
        else if (r < 88) cmd = wmcc_pkg::CMD_ADV_BTN;
        else if (r < 91) cmd = wmcc_pkg::CMD_REMOTE_ON;
        else if (r < 94) cmd = wmcc_pkg::CMD_REMOTE_OFF;
        else             cmd = wmcc_pkg::CMD_REMOTE_ADV;
        send_item(cmd, $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0, 1'b0, '0);
        burst--;
        left--;
      end
      if (left > 0 && $urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: switch between always ready, random stalls and a fixed pattern
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_span <= $urandom_range(16, 80);
    end else begin
      rx_span <= rx_span - 1;
    end
    rx_pat <= {rx_pat[6:0], rx_pat[7]};
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
      default:   out_tready <= rx_pat[0];
    endcase
  end

  // Check each result item against the oldest expectation
  always @(posedge clk) begin
    wmcc_pkg::result_t got;
    wmcc_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[21:0];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, got);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        compare_field("power_lamp", int'(want.drive.power), int'(got.drive.power));
        compare_field("level_lamp", int'(want.drive.level), int'(got.drive.level));
        compare_field("valve_on", int'(want.drive.valve), int'(got.drive.valve));
        compare_field("motor_on", int'(want.drive.motor), int'(got.drive.motor));
        compare_field("current_phase", int'(want.current_phase), int'(got.current_phase));
        compare_field("ticks_left", int'(want.ticks_left), int'(got.ticks_left));
        compare_field("timing", int'(want.timing), int'(got.timing));
        compare_field("report_valid", int'(want.report_valid), int'(got.report_valid));
        compare_field("report_code", int'(want.report_code), int'(got.report_code));
      end
    end
  end

  // Count cycles in which no channel moves an item
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [7:0] sweep [0:4];
    int i;
    // Directed walk: every command, idle events while off, a full countdown,
    // a command that drops a countdown, and the phase codes reported on the way
    dir_rows[0]  = row(wmcc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b1,
                       res(1'b0, 1'b0, 1'b0, 1'b0, wmcc_pkg::PH_OFF, 8'd0, 1'b0, 1'b0,
                           wmcc_pkg::PH_OFF));
    dir_rows[1]  = row(wmcc_pkg::CMD_SPARE, 1'b1, 1'b1, 1'b1,
                       res(1'b0, 1'b0, 1'b0, 1'b0, wmcc_pkg::PH_OFF, 8'd0, 1'b0, 1'b0,
                           wmcc_pkg::PH_OFF));
    dir_rows[2]  = row(wmcc_pkg::CMD_QUERY, 1'b0, 1'b0, 1'b1,
                       res(1'b0, 1'b0, 1'b0, 1'b0, wmcc_pkg::PH_OFF, 8'd0, 1'b0, 1'b1,
                           wmcc_pkg::PH_OFF));
    dir_rows[3]  = row(wmcc_pkg::CMD_ADV_BTN, 1'b0, 1'b0, 1'b1,
                       res(1'b0, 1'b0, 1'b0, 1'b0, wmcc_pkg::PH_OFF, 8'd0, 1'b0, 1'b1,
                           wmcc_pkg::PH_OFF));
    dir_rows[4]  = row(wmcc_pkg::CMD_POWER_BTN, 1'b0, 1'b0, 1'b1,
                       res(1'b1, 1'b0, 1'b1, 1'b1, wmcc_pkg::PH_AGITATE, 8'd0, 1'b0, 1'b1,
                           wmcc_pkg::PH_FILL));
    dir_rows[5]  = row(wmcc_pkg::CMD_TICK, 1'b0, 1'b1, 1'b0, '0);
    dir_rows[6]  = row(wmcc_pkg::CMD_QUERY, 1'b1, 1'b0, 1'b1,
                       res(1'b1, 1'b1, 1'b0, 1'b1, wmcc_pkg::PH_AGITATE, wmcc_pkg::TICKS_RESET,
                           1'b1, 1'b0, wmcc_pkg::PH_OFF));
    dir_rows[7]  = row(wmcc_pkg::CMD_QUERY, 1'b1, 1'b1, 1'b0, '0);
    dir_rows[8]  = row(wmcc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[9]  = row(wmcc_pkg::CMD_SPARE, 1'b1, 1'b0, 1'b0, '0);
    dir_rows[10] = row(wmcc_pkg::CMD_TICK, 1'b0, 1'b1, 1'b0, '0);
    dir_rows[11] = row(wmcc_pkg::CMD_TICK, 1'b1, 1'b1, 1'b0, '0);
    dir_rows[12] = row(wmcc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[13] = row(wmcc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[14] = row(wmcc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[15] = row(wmcc_pkg::CMD_TICK, 1'b0, 1'b1, 1'b0, '0);
    dir_rows[16] = row(wmcc_pkg::CMD_REMOTE_ADV, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[17] = row(wmcc_pkg::CMD_REMOTE_OFF, 1'b1, 1'b1, 1'b1,
                       res(1'b0, 1'b0, 1'b0, 1'b0, wmcc_pkg::PH_OFF, 8'd0, 1'b0, 1'b1,
                           wmcc_pkg::PH_OFF));
    dir_rows[18] = row(wmcc_pkg::CMD_REMOTE_ON, 1'b0, 1'b0, 1'b1,
                       res(1'b1, 1'b0, 1'b1, 1'b1, wmcc_pkg::PH_AGITATE, 8'd0, 1'b0, 1'b1,
                           wmcc_pkg::PH_FILL));
    dir_rows[19] = row(wmcc_pkg::CMD_ADV_BTN, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[20] = row(wmcc_pkg::CMD_POWER_BTN, 1'b0, 1'b1, 1'b1,
                       res(1'b0, 1'b0, 1'b0, 1'b0, wmcc_pkg::PH_OFF, 8'd0, 1'b0, 1'b1,
                           wmcc_pkg::PH_OFF));
    dir_rows[21] = row(wmcc_pkg::CMD_REMOTE_ADV, 1'b0, 1'b0, 1'b1,
                       res(1'b1, 1'b0, 1'b1, 1'b1, wmcc_pkg::PH_AGITATE, 8'd0, 1'b0, 1'b1,
                           wmcc_pkg::PH_FILL));
    dir_rows[22] = row(wmcc_pkg::CMD_ADV_BTN, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[23] = row(wmcc_pkg::CMD_ADV_BTN, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[24] = row(wmcc_pkg::CMD_ADV_BTN, 1'b0, 1'b0, 1'b0, '0);
    dir_rows[25] = row(wmcc_pkg::CMD_TICK, 1'b1, 1'b1, 1'b0, '0);

    sweep[0] = 8'd0;
    sweep[1] = 8'd255;
    sweep[2] = 8'd1;
    sweep[3] = 8'($urandom_range(2, 9));
    sweep[4] = 8'd3;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 26; i++) begin
      send_item(dir_rows[i].cmd, dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].known,
                dir_rows[i].want);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 3));
    end

    // Random sequences, one countdown setting at a time
    for (i = 0; i < 5; i++) begin
      write_phase_ticks(sweep[i]);
      run_random(ITEMS_PER_SETTING);
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> washing_machine_cycle_controller_core.f
design/wmcc_pkg.sv
design/wmcc_step.sv
design/washing_machine_cycle_controller_core.sv
tb/washing_machine_cycle_controller_core_tb.sv
